>>> sv/cpbac_pkg.sv
package cpbac_pkg;

  // field and register widths
  localparam int unsigned Q_W    = 20;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned IN_W   = 120;

  // unsigned Q2.30 loop gains, 33 bits wide to share the coefficient mux
  localparam logic [32:0] G_L_KP_OUT = 33'd87295210;
  localparam logic [32:0] G_L_KI_OUT = 33'd4402341;
  localparam logic [32:0] G_Q_KP_OUT = 33'd796823808;
  localparam logic [32:0] G_Q_KI_OUT = 33'd16750372;
  localparam logic [32:0] G_L_KP_IN  = 33'd72048076;
  localparam logic [32:0] G_L_KI_IN  = 33'd12777528;
  localparam logic [32:0] G_Q_KP_IN  = 33'd1065688760;
  localparam logic [32:0] G_Q_KI_IN  = 33'd1637563756;

  // 1.0 in Q1.32
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  // configuration register reset values
  localparam logic [DATA_W-1:0] TS_RESET    = 32'd42949673;
  localparam logic [DATA_W-1:0] RECIP_RESET = 32'd45887;

  // register indexes
  localparam logic REG_SAMPLE_PERIOD = 1'b0;
  localparam logic REG_BLEND_RECIP   = 1'b1;

  // last step of the schedule for one item
  localparam logic [4:0] STEP_LAST = 5'd28;

  // multiplier operand selects
  typedef enum logic [3:0] {
    X_ERR, X_AI, X_LI, X_PI, X_RL, X_RQ, X_AL, X_AQ, X_Q
  } xsel_t;

  typedef enum logic [3:0] {
    C_TS, C_RECIP, C_W, C_WINV,
    C_L_KP_OUT, C_L_KI_OUT, C_Q_KP_OUT, C_Q_KI_OUT,
    C_L_KP_IN, C_L_KI_IN, C_Q_KP_IN, C_Q_KI_IN
  } csel_t;

  typedef enum logic [2:0] {PD_P0, PD_P1, PD_P2, PD_P3, PD_W} pdst_t;

  typedef struct packed {
    logic  issue;
    xsel_t x;
    csel_t c;
    logic  s32;   // shift by 32 instead of 30
    logic  raw;   // plain product clamped to 1.0 (blend weight)
    pdst_t dst;
  } mul_cmd_t;

  // saturating adder selects
  typedef enum logic [2:0] {A_AI, A_LI, A_PI, A_RL, A_RQ, A_P0, A_P1, A_P2} asel_t;
  typedef enum logic [1:0] {B_P0, B_P1, B_P3, B_NRATE} bsel_t;
  typedef enum logic [1:0] {LIM_WIDE, LIM_INTEG, LIM_OUT} lim_t;
  typedef enum logic [2:0] {D_AI, D_LI, D_PI, D_RL, D_RQ, D_AL, D_AQ, D_Y} adst_t;

  typedef struct packed {
    logic  en;
    asel_t a;
    bsel_t b;
    lim_t  lim;
    adst_t dst;
  } alu_cmd_t;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

endpackage

>>> sv/cascaded_pi_blended_attitude_control_unit.sv
// Channel  Dir  Width  Contents
// in_      in   120    dynamic_pressure, body_rate, attitude_angle, angle_command
// out_     out  32     actuator_command
// cfg_     in   32     sample_period (0x0), blend_reciprocal (0x4), APB-style
//
// Each item is taken in an accept cycle and then runs a 29-step schedule that
// runs 13 scaled products and one blend-weight product through a single
// 4-stage multiply unit (two 32x33 multipliers) and a saturating adder.
// The result sits in an output register; the next item is taken while it waits.
// A new result is held at its last step until the output register is free.
// rst_n is synchronous; it clears the integrators, the controller and valids and resets the cfg registers.
module cascaded_pi_blended_attitude_control_unit #(
  parameter int INTEGRATOR_WIDTH = 48
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // dynamic_pressure[19:0], body_rate[51:20], attitude_angle[83:52],
  // angle_command[115:84], zero fill [119:116]
  input  logic [cpbac_pkg::IN_W-1:0]       in_tdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // actuator_command[31:0]
  output logic [cpbac_pkg::DATA_W-1:0]     out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [cpbac_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [cpbac_pkg::DATA_W-1:0]     cfg_pwdata,
  output logic [cpbac_pkg::DATA_W-1:0]     cfg_prdata,
  output logic                             cfg_pready
);
  import cpbac_pkg::*;

  logic [DATA_W-1:0]        ts_r, recip_r;
  logic                     cfg_wr;
  logic                     load;
  mul_cmd_t                 mul_cmd;
  alu_cmd_t                 alu_cmd;
  logic signed [DATA_W-1:0] actuator_command;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r    <= TS_RESET;
      recip_r <= RECIP_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_SAMPLE_PERIOD) ts_r <= cfg_pwdata;
      if (cfg_paddr[2] == REG_BLEND_RECIP)   recip_r <= cfg_pwdata;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_BLEND_RECIP) ? recip_r : ts_r;

  cpbac_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .load       (load),
    .mul_cmd    (mul_cmd),
    .alu_cmd    (alu_cmd)
  );

  cpbac_dp #(
    .INTEGRATOR_WIDTH (INTEGRATOR_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (load),
    .dynamic_pressure (in_tdata[19:0]),
    .body_rate        (in_tdata[51:20]),
    .attitude_angle   (in_tdata[83:52]),
    .angle_command    (in_tdata[115:84]),
    .sample_period    (ts_r),
    .blend_reciprocal (recip_r),
    .mul_cmd          (mul_cmd),
    .alu_cmd          (alu_cmd),
    .actuator_command (actuator_command)
  );

  assign out_tdata = actuator_command;

endmodule

>>> sv/cpbac_ctrl.sv
module cpbac_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic                load,
  output cpbac_pkg::mul_cmd_t mul_cmd,
  output cpbac_pkg::alu_cmd_t alu_cmd
);
  import cpbac_pkg::*;

  state_t     state_r, state_nxt;
  logic [4:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       fin;

  function automatic mul_cmd_t mul(xsel_t x, csel_t c, pdst_t d);
    mul_cmd_t m;
    m.issue = 1'b1;
    m.x     = x;
    m.c     = c;
    m.s32   = (c == C_TS) || (c == C_W) || (c == C_WINV);
    m.raw   = (x == X_Q);
    m.dst   = d;
    return m;
  endfunction

  function automatic alu_cmd_t alu(asel_t a, bsel_t b, lim_t l, adst_t d);
    alu_cmd_t r;
    r.en  = 1'b1;
    r.a   = a;
    r.b   = b;
    r.lim = l;
    r.dst = d;
    return r;
  endfunction

  // handshake
  assign in_tready  = (state_r == ST_IDLE);
  assign load       = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;
  assign fin        = (state_r == ST_RUN) && (step_r == STEP_LAST) && out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (load) begin
          state_nxt = ST_RUN;
          step_nxt  = '0;
        end
      end
      ST_RUN: begin
        if (step_r == STEP_LAST) begin
          if (out_free) state_nxt = ST_IDLE;
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (fin) out_valid_nxt = 1'b1;
  end

  // schedule: a product issued at a step passes m_r/c_r, ph_r/pl_r and mag_r before it is written back
  always_comb begin
    mul_cmd = '0;
    alu_cmd = '0;
    if (state_r == ST_RUN) begin
      unique case (step_r)
        5'd0:  mul_cmd = mul(X_ERR, C_TS, PD_P0);
        5'd1:  mul_cmd = mul(X_ERR, C_L_KP_OUT, PD_P1);
        5'd2:  mul_cmd = mul(X_ERR, C_Q_KP_OUT, PD_P2);
        5'd3:  mul_cmd = mul(X_Q, C_RECIP, PD_W);
        5'd4:  alu_cmd = alu(A_AI, B_P0, LIM_INTEG, D_AI);
        5'd5:  mul_cmd = mul(X_AI, C_L_KI_OUT, PD_P0);
        5'd6:  mul_cmd = mul(X_AI, C_Q_KI_OUT, PD_P3);
        5'd9:  alu_cmd = alu(A_P1, B_P0, LIM_WIDE, D_RL);
        5'd10: alu_cmd = alu(A_RL, B_NRATE, LIM_WIDE, D_RL);
        5'd11: begin
          mul_cmd = mul(X_RL, C_TS, PD_P0);
          alu_cmd = alu(A_P2, B_P3, LIM_WIDE, D_RQ);
        end
        5'd12: alu_cmd = alu(A_RQ, B_NRATE, LIM_WIDE, D_RQ);
        5'd13: mul_cmd = mul(X_RQ, C_TS, PD_P3);
        5'd14: mul_cmd = mul(X_RL, C_L_KP_IN, PD_P1);
        5'd15: begin
          mul_cmd = mul(X_RQ, C_Q_KP_IN, PD_P2);
          alu_cmd = alu(A_LI, B_P0, LIM_INTEG, D_LI);
        end
        5'd16: mul_cmd = mul(X_LI, C_L_KI_IN, PD_P0);
        5'd17: alu_cmd = alu(A_PI, B_P3, LIM_INTEG, D_PI);
        5'd18: mul_cmd = mul(X_PI, C_Q_KI_IN, PD_P3);
        5'd20: alu_cmd = alu(A_P1, B_P0, LIM_WIDE, D_AL);
        5'd22: alu_cmd = alu(A_P2, B_P3, LIM_WIDE, D_AQ);
        5'd23: mul_cmd = mul(X_AL, C_WINV, PD_P0);
        5'd24: mul_cmd = mul(X_AQ, C_W, PD_P1);
        5'd28: begin
          if (out_free) alu_cmd = alu(A_P0, B_P1, LIM_OUT, D_Y);
        end
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> sv/cpbac_dp.sv
module cpbac_dp #(
  parameter int INTEGRATOR_WIDTH = 48
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  logic [cpbac_pkg::Q_W-1:0]            dynamic_pressure,
  input  logic signed [cpbac_pkg::DATA_W-1:0]  body_rate,
  input  logic signed [cpbac_pkg::DATA_W-1:0]  attitude_angle,
  input  logic signed [cpbac_pkg::DATA_W-1:0]  angle_command,
  input  logic [cpbac_pkg::DATA_W-1:0]         sample_period,
  input  logic [cpbac_pkg::DATA_W-1:0]         blend_reciprocal,
  input  cpbac_pkg::mul_cmd_t                  mul_cmd,
  input  cpbac_pkg::alu_cmd_t                  alu_cmd,
  output logic signed [cpbac_pkg::DATA_W-1:0]  actuator_command
);
  import cpbac_pkg::*;

  localparam int IW = INTEGRATOR_WIDTH;
  localparam logic signed [64:0] ILIM_HI = (65'sd1 <<< (IW - 1)) - 65'sd1;
  localparam logic signed [64:0] ILIM_LO = -(65'sd1 <<< (IW - 1));
  localparam logic signed [64:0] WLIM_HI = 65'sd1 <<< 62;
  localparam logic signed [64:0] WLIM_LO = -(65'sd1 <<< 62) - 65'sd1;
  localparam logic signed [64:0] OLIM_HI = 65'sd2147483647;
  localparam logic signed [64:0] OLIM_LO = -65'sd2147483648;
  localparam logic [66:0]        MAG_LIM = 67'd1 << 62;

  typedef struct packed {
    logic  vld;
    logic  neg;
    logic  s32;
    logic  raw;
    pdst_t dst;
  } tag_t;

  // sample registers
  logic [Q_W-1:0]     q_r;
  logic signed [32:0] err_r;
  logic signed [32:0] nrate_r;

  // loop state and intermediates
  logic signed [IW-1:0] ai_r, li_r, pi_r;
  logic signed [63:0]   rl_r, rq_r, al_r, aq_r;
  logic signed [63:0]   p0_r, p1_r, p2_r, p3_r;
  logic [32:0]          w_r;
  logic signed [31:0]   y_r;

  // product pipeline
  tag_t         t1_r, t2_r, t3_r;
  logic [63:0]  m_r;
  logic [32:0]  c_r;
  logic [64:0]  ph_r, pl_r;
  logic [62:0]  mag_r;

  logic signed [63:0] xv;
  logic [63:0]        m_nxt;
  logic [32:0]        c_nxt;
  logic [96:0]        total;
  logic [96:0]        rnd;
  logic [66:0]        sh;
  logic [62:0]        mag_nxt;
  logic signed [63:0] res;

  logic signed [63:0] a_op, b_op;
  logic signed [64:0] sum, lim_hi, lim_lo, sat;

  // operand select and magnitude
  always_comb begin
    case (mul_cmd.x)
      X_ERR:   xv = 64'(err_r);
      X_AI:    xv = 64'(ai_r);
      X_LI:    xv = 64'(li_r);
      X_PI:    xv = 64'(pi_r);
      X_RL:    xv = rl_r;
      X_RQ:    xv = rq_r;
      X_AL:    xv = al_r;
      X_AQ:    xv = aq_r;
      X_Q:     xv = 64'(q_r);
      default: xv = '0;
    endcase
    m_nxt = xv[63] ? 64'(-xv) : 64'(xv);
  end

  // coefficient select
  always_comb begin
    case (mul_cmd.c)
      C_TS:       c_nxt = {1'b0, sample_period};
      C_RECIP:    c_nxt = {1'b0, blend_reciprocal};
      C_W:        c_nxt = w_r;
      C_WINV:     c_nxt = ONE_Q32 - w_r;
      C_L_KP_OUT: c_nxt = G_L_KP_OUT;
      C_L_KI_OUT: c_nxt = G_L_KI_OUT;
      C_Q_KP_OUT: c_nxt = G_Q_KP_OUT;
      C_Q_KI_OUT: c_nxt = G_Q_KI_OUT;
      C_L_KP_IN:  c_nxt = G_L_KP_IN;
      C_L_KI_IN:  c_nxt = G_L_KI_IN;
      C_Q_KP_IN:  c_nxt = G_Q_KP_IN;
      C_Q_KI_IN:  c_nxt = G_Q_KI_IN;
      default:    c_nxt = '0;
    endcase
  end

  // combine partial products, round half away (on magnitude), saturate
  always_comb begin
    rnd     = t2_r.s32 ? (97'd1 << 31) : (97'd1 << 29);
    total   = {ph_r, 32'd0} + {32'd0, pl_r} + rnd;
    sh      = t2_r.s32 ? {2'b00, total[96:32]} : total[96:30];
    mag_nxt = (sh > MAG_LIM) ? MAG_LIM[62:0] : sh[62:0];
    if (t2_r.raw) begin
      mag_nxt = (pl_r > 65'(ONE_Q32)) ? 63'(ONE_Q32) : 63'(pl_r);
    end
  end

  // restore sign
  assign res = t3_r.neg ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});

  // saturating adder
  always_comb begin
    case (alu_cmd.a)
      A_AI:    a_op = 64'(ai_r);
      A_LI:    a_op = 64'(li_r);
      A_PI:    a_op = 64'(pi_r);
      A_RL:    a_op = rl_r;
      A_RQ:    a_op = rq_r;
      A_P0:    a_op = p0_r;
      A_P1:    a_op = p1_r;
      A_P2:    a_op = p2_r;
      default: a_op = '0;
    endcase
    case (alu_cmd.b)
      B_P0:    b_op = p0_r;
      B_P1:    b_op = p1_r;
      B_P3:    b_op = p3_r;
      B_NRATE: b_op = 64'(nrate_r);
      default: b_op = '0;
    endcase
    case (alu_cmd.lim)
      LIM_INTEG: begin
        lim_hi = ILIM_HI;
        lim_lo = ILIM_LO;
      end
      LIM_OUT: begin
        lim_hi = OLIM_HI;
        lim_lo = OLIM_LO;
      end
      default: begin
        lim_hi = WLIM_HI;
        lim_lo = WLIM_LO;
      end
    endcase
    sum = 65'(a_op) + 65'(b_op);
    if (sum > lim_hi)      sat = lim_hi;
    else if (sum < lim_lo) sat = lim_lo;
    else                   sat = sum;
  end

  // pipeline valid tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r <= '0;
      t2_r <= '0;
      t3_r <= '0;
    end else begin
      t1_r.vld <= mul_cmd.issue;
      t1_r.neg <= xv[63];
      t1_r.s32 <= mul_cmd.s32;
      t1_r.raw <= mul_cmd.raw;
      t1_r.dst <= mul_cmd.dst;
      t2_r     <= t1_r;
      t3_r     <= t2_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    m_r   <= m_nxt;
    c_r   <= c_nxt;
    ph_r  <= {33'd0, m_r[63:32]} * {32'd0, c_r};
    pl_r  <= {33'd0, m_r[31:0]} * {32'd0, c_r};
    mag_r <= mag_nxt;
  end

  // sample capture, product and sum write-back
  always_ff @(posedge clk) begin
    if (load) begin
      q_r     <= dynamic_pressure;
      err_r   <= 33'(angle_command) - 33'(attitude_angle);
      nrate_r <= -33'(body_rate);
    end
    if (t3_r.vld) begin
      case (t3_r.dst)
        PD_P0:   p0_r <= res;
        PD_P1:   p1_r <= res;
        PD_P2:   p2_r <= res;
        PD_P3:   p3_r <= res;
        PD_W:    w_r  <= res[32:0];
        default: ;
      endcase
    end
    if (alu_cmd.en) begin
      case (alu_cmd.dst)
        D_RL:    rl_r <= sat[63:0];
        D_RQ:    rq_r <= sat[63:0];
        D_AL:    al_r <= sat[63:0];
        D_AQ:    aq_r <= sat[63:0];
        D_Y:     y_r  <= sat[31:0];
        default: ;
      endcase
    end
  end

  // integrators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ai_r <= '0;
      li_r <= '0;
      pi_r <= '0;
    end else if (alu_cmd.en) begin
      case (alu_cmd.dst)
        D_AI:    ai_r <= sat[IW-1:0];
        D_LI:    li_r <= sat[IW-1:0];
        D_PI:    pi_r <= sat[IW-1:0];
        default: ;
      endcase
    end
  end

  assign actuator_command = y_r;

endmodule
